### rtl/core/box_mean_filter_3x3_rgb_core_defines.svh
// ----------------------------------------------------------------------------
// box mean filter assertion macros
// Shared property macros for the box mean filter core. They sample on i_clk
// and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOX_MEAN_FILTER_3X3_RGB_CORE_DEFINES_SVH
`define BOX_MEAN_FILTER_3X3_RGB_CORE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define BMF_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("box mean filter check failed");

// condition must hold in the cycle after the trigger
`define BMF_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("box mean filter check failed");

`endif

### rtl/core/bmf_pkg.sv
// ----------------------------------------------------------------------------
// box mean filter package
// Sizes, word types, register indexes and the divisor reciprocal table
// shared by the box mean filter core and its sub-blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

    // geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = 12;
    localparam int FH_W      = 13;
    localparam int ROW_W     = FH_W + 1;
    localparam int EFFW_W    = (FW_W > $clog2(MAX_WIDTH + 1)) ? FW_W : $clog2(MAX_WIDTH + 1);
    localparam int WIN       = 3;

    // arithmetic widths
    localparam int CH_W        = 8;
    localparam int CSUM_W      = CH_W + 2;
    localparam int SUM_W       = CH_W + 4;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FH_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // operation codes
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] avg_red;
        logic [CH_W-1:0] avg_green;
        logic [CH_W-1:0] avg_blue;
        logic            frame_last;
    } t_out_word;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pixel;

    // one window column, top row first
    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
        t_pixel lower;
    } t_column;

    typedef struct packed {
        logic [CSUM_W-1:0] blue;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] red;
    } t_csum;

    // which rows of a column lie inside the frame
    typedef struct packed {
        logic top;
        logic bottom;
    } t_row_mask;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_DIV
    } t_state;

    // 2^16 / count rounded up; exact floor division for sums below 2^15
    function automatic logic [RECIP_W-1:0] bmf_recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        case (count)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bmf_ram.sv
// ----------------------------------------------------------------------------
// generic single-port ram
// One read/write address, write when enabled, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/bmf_cell.sv
// ----------------------------------------------------------------------------
// box mean filter window cell
// Holds one three-pixel column of the window, passes it to the left neighbor
// on a shift and gives the per-channel sum of its rows inside the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_cell
    import bmf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_shift,
    input  wire t_column   i_col,
    input  wire t_row_mask i_mask,
    output t_column        o_col,
    output t_csum          o_sum
);

    t_column r_col;

    // column register, loads from the right-hand neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // masked column sum per channel
    always_comb begin
        o_sum.red   = (i_mask.top ? CSUM_W'(r_col.upper.red) : '0)
                    + CSUM_W'(r_col.middle.red)
                    + (i_mask.bottom ? CSUM_W'(r_col.lower.red) : '0);
        o_sum.green = (i_mask.top ? CSUM_W'(r_col.upper.green) : '0)
                    + CSUM_W'(r_col.middle.green)
                    + (i_mask.bottom ? CSUM_W'(r_col.lower.green) : '0);
        o_sum.blue  = (i_mask.top ? CSUM_W'(r_col.upper.blue) : '0)
                    + CSUM_W'(r_col.middle.blue)
                    + (i_mask.bottom ? CSUM_W'(r_col.lower.blue) : '0);
    end

endmodule

`default_nettype wire

### rtl/core/box_mean_filter_3x3_rgb_core.sv
// Sequence: a word that yields a result passes the line store read, the window
//   sum and the reciprocal multiply and then loads the output register, held
//   while the output stalls. A new word is taken only in the idle state, after
//   the single-port line store read and its write-back and, for a word with a
//   result, the sum and multiply stages; an ignored drain word leaves it idle.
// Reset: position counters cleared, frame size 640 x 480, line stores not cleared.
// ----------------------------------------------------------------------------
// box mean filter 3x3 rgb core
// Truncated 3x3 neighborhood mean per channel of a raster pixel stream, with
// two line stores and a chain of three window column cells.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_mean_filter_3x3_rgb_core_defines.svh"

module box_mean_filter_3x3_rgb_core
    import bmf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_word                  o_out_word
);

    t_state r_state, n_state;

    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [EFFW_W-1:0] w_eff, w_fw_ext;
    logic [FH_W-1:0]   h_eff;

    logic [COL_W-1:0] r_in_col, r_out_col;
    logic [ROW_W-1:0] r_in_row;
    logic [FH_W-1:0]  r_out_row;

    t_pixel  r_pix;
    t_pixel  w_up_rd, w_lo_rd;
    t_column w_new_col;
    t_column w_cell_in  [WIN];
    t_column w_cell_out [WIN];
    t_csum   w_cell_sum [WIN];

    logic w_in_acc, w_frame_done, w_ignore, w_emit;
    logic w_shift, w_ram_we, w_load_out, w_out_free;
    logic w_left, w_right, w_last;
    t_row_mask w_mask;
    logic [1:0]       w_rows, w_cols;
    logic [CNT_W-1:0] w_count;

    logic [SUM_W-1:0]   r_sum_red, r_sum_green, r_sum_blue;
    logic [RECIP_W-1:0] r_recip;
    logic               r_last;
    logic [PROD_W-1:0]  w_prod_red, w_prod_green, w_prod_blue;

    t_out_word r_out;
    logic      r_out_valid;

    // effective frame size
    always_comb begin
        w_fw_ext = EFFW_W'(r_frame_width);
        if (r_frame_width == '0) begin
            w_eff = EFFW_W'(1);
        end else if (w_fw_ext > EFFW_W'(MAX_WIDTH)) begin
            w_eff = EFFW_W'(MAX_WIDTH);
        end else begin
            w_eff = w_fw_ext;
        end
        h_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    // input side decisions
    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_acc     = i_in_valid && (r_state == S_IDLE);
    assign w_frame_done = (r_in_row >= ROW_W'(h_eff));
    assign w_ignore     = !w_frame_done && (i_in_word.operation == OP_DRAIN);
    assign w_emit       = (r_in_row >= ROW_W'(2)) || ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
    assign w_out_free   = !r_out_valid || !i_out_stall;

    // neighborhood bounds of the current output pixel
    always_comb begin
        w_mask.top    = (r_out_row != '0);
        w_mask.bottom = ((ROW_W'(r_out_row) + ROW_W'(1)) < ROW_W'(h_eff));
        w_left        = (r_out_col != '0);
        w_right       = ((EFFW_W'(r_out_col) + EFFW_W'(1)) < w_eff);
        w_last        = !w_mask.bottom && !w_right;
        w_rows        = 2'd1 + 2'(w_mask.top) + 2'(w_mask.bottom);
        w_cols        = 2'd1 + 2'(w_left) + 2'(w_right);
        w_count       = CNT_W'(w_rows) * CNT_W'(w_cols);
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        w_shift    = 1'b0;
        w_ram_we   = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && !w_ignore) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                w_shift  = 1'b1;
                w_ram_we = 1'b1;
                n_state  = w_emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // position counters, restarted by a register write or the frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (r_state == S_LOAD) begin
                if ((EFFW_W'(r_in_col) + EFFW_W'(1)) >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (w_load_out) begin
                if (r_last) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if ((EFFW_W'(r_out_col) + EFFW_W'(1)) >= w_eff) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + FH_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

    // incoming pixel, zero once the frame is complete
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (w_frame_done) begin
                r_pix <= '0;
            end else begin
                r_pix.red   <= i_in_word.in_red;
                r_pix.green <= i_in_word.in_green;
                r_pix.blue  <= i_in_word.in_blue;
            end
        end
    end

    // line stores: upper holds two rows back, lower one row back
    bmf_ram #(
        .WIDTH ($bits(t_pixel)),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (r_in_col),
        .i_wdata (w_lo_rd),
        .o_rdata (w_up_rd)
    );

    bmf_ram #(
        .WIDTH ($bits(t_pixel)),
        .DEPTH (MAX_WIDTH)
    ) u_line_lower (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (r_in_col),
        .i_wdata (r_pix),
        .o_rdata (w_lo_rd)
    );

    assign w_new_col.upper  = w_up_rd;
    assign w_new_col.middle = w_lo_rd;
    assign w_new_col.lower  = r_pix;

    // window: new column enters the rightmost cell and moves left
    for (genvar gi = 0; gi < WIN; gi++) begin : g_cell
        if (gi == WIN - 1) begin : g_head
            assign w_cell_in[gi] = w_new_col;
        end else begin : g_link
            assign w_cell_in[gi] = w_cell_out[gi + 1];
        end

        bmf_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_col   (w_cell_in[gi]),
            .i_mask  (w_mask),
            .o_col   (w_cell_out[gi]),
            .o_sum   (w_cell_sum[gi])
        );
    end

    // neighborhood sums and divisor reciprocal
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_sum_red   <= (w_left ? SUM_W'(w_cell_sum[0].red) : '0)
                         + SUM_W'(w_cell_sum[1].red)
                         + (w_right ? SUM_W'(w_cell_sum[2].red) : '0);
            r_sum_green <= (w_left ? SUM_W'(w_cell_sum[0].green) : '0)
                         + SUM_W'(w_cell_sum[1].green)
                         + (w_right ? SUM_W'(w_cell_sum[2].green) : '0);
            r_sum_blue  <= (w_left ? SUM_W'(w_cell_sum[0].blue) : '0)
                         + SUM_W'(w_cell_sum[1].blue)
                         + (w_right ? SUM_W'(w_cell_sum[2].blue) : '0);
            r_recip     <= bmf_recip(w_count);
            r_last      <= w_last;
        end
    end

    // division by reciprocal multiply
    assign w_prod_red   = PROD_W'(r_sum_red) * PROD_W'(r_recip);
    assign w_prod_green = PROD_W'(r_sum_green) * PROD_W'(r_recip);
    assign w_prod_blue  = PROD_W'(r_sum_blue) * PROD_W'(r_recip);

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.avg_red    <= w_prod_red[RECIP_SHIFT +: CH_W];
            r_out.avg_green  <= w_prod_green[RECIP_SHIFT +: CH_W];
            r_out.avg_blue   <= w_prod_blue[RECIP_SHIFT +: CH_W];
            r_out.frame_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    `BMF_ASSERT_NEXT(a_load_after_accept, w_in_acc && !w_ignore, r_state == S_LOAD)
    `BMF_ASSERT_NEXT(a_div_waits, (r_state == S_DIV) && !w_out_free,
        (r_state == S_DIV) && r_out_valid && $stable(r_out))
    `BMF_ASSERT_NOW(a_col_in_range, r_state == S_IDLE, EFFW_W'(r_in_col) < w_eff)
    `BMF_ASSERT_NEXT(a_frame_end_restart, w_load_out && r_last,
        (r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0) && (r_out_row == '0))

endmodule

`default_nettype wire
